@@ sv/rewind_history_buffer_core_assert.svh @@
// Assertion macros for the rewind history buffer; empty when synthesized.
`ifndef REWIND_HISTORY_BUFFER_CORE_ASSERT_SVH
`define REWIND_HISTORY_BUFFER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RHB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RHB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHB_ASSERT(lbl, clk, rst_n, prop, msg)
`define RHB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/rhb_pkg.sv @@
// Shared types and constants of the rewind history buffer.
package rhb_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] OP_TICK         = 2'd0;
    localparam logic [1:0] OP_START_REWIND = 2'd1;
    localparam logic [1:0] OP_STOP_REWIND  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RECORD_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MAX_SNAPSHOTS   = 2'd1;
    localparam logic [1:0] CFG_REWIND_TICK     = 2'd2;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 20;

    // Register reset values.
    localparam logic [19:0] RECORD_INTERVAL_RST = 20'd50000;
    localparam logic [7:0]  MAX_SNAPSHOTS_RST   = 8'd100;
    localparam logic [7:0]  REWIND_TICK_RST     = 8'd1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
    } t_pose;

    typedef struct packed {
        logic push;
        logic pop;
    } t_step;

endpackage

@@ sv/rhb_ifs.sv @@
// Channel interfaces of the rewind history buffer: input, result and configuration.
interface rhb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [19:0]        delta_us;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] ang_pitch;
    logic signed [15:0] ang_yaw;
    logic signed [15:0] ang_roll;

    modport source (output valid, op, delta_us, pos_x, pos_y, pos_z,
                    ang_pitch, ang_yaw, ang_roll, input ready);
    modport sink (input valid, op, delta_us, pos_x, pos_y, pos_z,
                  ang_pitch, ang_yaw, ang_roll, output ready);
endinterface

interface rhb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_pitch;
    logic signed [15:0] out_yaw;
    logic signed [15:0] out_roll;
    logic [7:0]         entries_left;

    modport source (output valid, out_x, out_y, out_z, out_pitch, out_yaw,
                    out_roll, entries_left, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_pitch, out_yaw,
                  out_roll, entries_left, output ready);
endinterface

interface rhb_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rhb_pkg::CFG_IW-1:0] index;
    logic [rhb_pkg::CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/rhb_store.sv @@
// Snapshot register file: one write port and one registered read port.
module rhb_store #(
    parameter int DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  rhb_pkg::t_pose         i_wdata,
    input  logic                   i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output rhb_pkg::t_pose         o_rdata
);

    rhb_pkg::t_pose mem [DEPTH];
    rhb_pkg::t_pose r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rhb_ctrl.sv @@
// Record and rewind control: configuration, timers, ring pointers and push/pop decisions.
`include "rewind_history_buffer_core_assert.svh"

module rhb_ctrl #(
    parameter int DEPTH = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rhb_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [rhb_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_accept,
    input  logic [1:0]                  i_op,
    input  logic [19:0]                 i_delta_us,
    output rhb_pkg::t_step              o_step,
    output logic [$clog2(DEPTH)-1:0]    o_waddr,
    output logic [$clog2(DEPTH)-1:0]    o_raddr,
    output logic [7:0]                  o_entries_left
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int LW = (CW > 8) ? CW : 8;

    logic [19:0]   r_interval;
    logic [7:0]    r_max;
    logic [7:0]    r_rti;
    logic          r_rewinding, n_rewinding;
    logic [20:0]   r_timer, n_timer;
    logic [7:0]    r_rc, n_rc;
    logic [IW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_count, n_count;

    logic [20:0]   timer_sum;
    logic          rec_hit;
    logic          is_tick;
    logic          empty;
    logic [7:0]    rc_inc;
    logic [7:0]    every;
    logic          push;
    logic          pop;
    logic          full;
    logic [LW-1:0] max_ext;
    logic [LW-1:0] limit;
    logic [LW-1:0] c1;
    logic [LW-1:0] c2;
    logic          drop;
    logic [IW-1:0] inc1;
    logic [IW-1:0] inc2;

    // Ring index wrap; the sum is below twice the depth except in the read address of an empty ring.
    function automatic logic [IW-1:0] wrap(input logic [SW-1:0] s);
        if (s >= SW'(DEPTH)) begin
            return IW'(s - SW'(DEPTH));
        end
        return IW'(s);
    endfunction

    assign is_tick   = (i_op == rhb_pkg::OP_TICK);
    assign timer_sum = r_timer + 21'(i_delta_us);
    assign rec_hit   = (timer_sum >= 21'(r_interval));
    assign empty     = (r_count == '0);
    assign rc_inc    = r_rc + 8'd1;
    assign every     = (r_rti == 8'd0) ? 8'd1 : r_rti;
    assign push      = is_tick && !r_rewinding && rec_hit;
    assign pop       = is_tick && r_rewinding && !empty && (rc_inc >= every);

    // A push into a full ring overwrites the oldest slot after dropping it.
    assign full    = (r_count == CW'(DEPTH));
    assign max_ext = LW'(r_max);
    assign limit   = (max_ext < LW'(DEPTH)) ? max_ext : LW'(DEPTH);
    assign c1      = full ? LW'(DEPTH - 1) : LW'(r_count);
    assign c2      = c1 + LW'(1);
    assign drop    = (c2 > limit);
    assign inc1    = wrap(SW'(r_oldest) + SW'(1));
    assign inc2    = wrap(SW'(r_oldest) + SW'(2));

    assign o_waddr = full ? r_oldest : wrap(SW'(r_oldest) + SW'(r_count));
    assign o_raddr = wrap(SW'(r_oldest) + SW'(r_count) - SW'(1));
    assign o_step  = '{push: push, pop: pop};
    assign o_entries_left = 8'(r_count - CW'(1));

    always_comb begin
        n_rewinding = r_rewinding;
        n_timer     = r_timer;
        n_rc        = r_rc;
        n_oldest    = r_oldest;
        n_count     = r_count;
        case (i_op)
            rhb_pkg::OP_START_REWIND: begin
                n_rewinding = 1'b1;
            end
            rhb_pkg::OP_STOP_REWIND: begin
                n_rewinding = 1'b0;
            end
            rhb_pkg::OP_TICK: begin
                if (!r_rewinding) begin
                    n_timer = rec_hit ? 21'd0 : timer_sum;
                    if (rec_hit) begin
                        n_count = drop ? CW'(c1) : CW'(c2);
                        if (full) begin
                            n_oldest = drop ? inc2 : inc1;
                        end else begin
                            n_oldest = drop ? inc1 : r_oldest;
                        end
                    end
                end else if (empty) begin
                    n_rewinding = 1'b0;
                end else if (rc_inc < every) begin
                    n_rc = rc_inc;
                end else begin
                    n_rc    = 8'd0;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= rhb_pkg::RECORD_INTERVAL_RST;
            r_max       <= rhb_pkg::MAX_SNAPSHOTS_RST;
            r_rti       <= rhb_pkg::REWIND_TICK_RST;
            r_rewinding <= 1'b0;
            r_timer     <= '0;
            r_rc        <= '0;
            r_oldest    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rhb_pkg::CFG_RECORD_INTERVAL: r_interval <= i_cfg_data;
                    rhb_pkg::CFG_MAX_SNAPSHOTS:   r_max      <= i_cfg_data[7:0];
                    rhb_pkg::CFG_REWIND_TICK:     r_rti      <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_rewinding <= n_rewinding;
                r_timer     <= n_timer;
                r_rc        <= n_rc;
                r_oldest    <= n_oldest;
                r_count     <= n_count;
            end
        end
    end

    `RHB_ASSERT(a_count_in_range, i_clk, i_rst_n, r_count <= CW'(DEPTH), "entry count above depth")
    `RHB_ASSERT(a_push_pop_excl, i_clk, i_rst_n, !(push && pop), "push and pop in one item")
    `RHB_ASSERT(a_pop_needs_entry, i_clk, i_rst_n, pop |-> (r_rewinding && !empty), "pop while empty")
    `RHB_ASSERT(a_pop_drops_one, i_clk, i_rst_n, (i_accept && pop) |=> (CW'(r_count + CW'(1)) == $past(r_count)), "pop did not lower count by one")

endmodule

@@ sv/rewind_history_buffer_core.sv @@
// A tick that pops a snapshot shows its result in the cycle after it is accepted.
// Throughput: one item per cycle, set by the snapshot register file, which takes one
// write and one registered read each cycle; a held result stalls only popping ticks.
// Reset is synchronous and active low: it restores the default configuration, empties
// the history and stops rewinding. The snapshot store has no reset and no clearing pass.
// Top level of the rewind history buffer.
module rewind_history_buffer_core #(
    parameter int DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rhb_in_if.sink    i_in,
    rhb_out_if.source o_out,
    rhb_cfg_if.sink   i_cfg
);

    localparam int IW = $clog2(DEPTH);

    rhb_pkg::t_step step;
    rhb_pkg::t_pose wdata;
    rhb_pkg::t_pose rdata;
    logic [IW-1:0]  waddr;
    logic [IW-1:0]  raddr;
    logic [7:0]     entries_left;
    logic           in_ready;
    logic           in_fire;
    logic           r_out_valid;
    logic [7:0]     r_entries_left;

    // Configuration writes are always taken; keeping them to idle is up to the user.
    assign i_cfg.ready = 1'b1;

    // The store's read register doubles as the result register, so only a tick
    // that pops has to wait for a pending result to drain. Every other item,
    // pushes included, keeps flowing because the held read data is untouched.
    assign in_ready   = !r_out_valid || o_out.ready || !step.pop;
    assign i_in.ready = in_ready;
    assign in_fire    = i_in.valid && in_ready;

    assign wdata = '{x: i_in.pos_x, y: i_in.pos_y, z: i_in.pos_z,
                     pitch: i_in.ang_pitch, yaw: i_in.ang_yaw, roll: i_in.ang_roll};

    rhb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg.valid && i_cfg.ready),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_accept       (in_fire),
        .i_op           (i_in.op),
        .i_delta_us     (i_in.delta_us),
        .o_step         (step),
        .o_waddr        (waddr),
        .o_raddr        (raddr),
        .o_entries_left (entries_left)
    );

    rhb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_fire && step.push),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (in_fire && step.pop),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Result valid is set by a popping tick and cleared once the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && step.pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The remaining count travels alongside the read data.
    always_ff @(posedge i_clk) begin
        if (in_fire && step.pop) begin
            r_entries_left <= entries_left;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_x        = rdata.x;
    assign o_out.out_y        = rdata.y;
    assign o_out.out_z        = rdata.z;
    assign o_out.out_pitch    = rdata.pitch;
    assign o_out.out_yaw      = rdata.yaw;
    assign o_out.out_roll     = rdata.roll;
    assign o_out.entries_left = r_entries_left;

endmodule

@@ tb/rewind_history_buffer_core_test.sv @@
// Self-checking testbench of the rewind history buffer: directed cases, extremes and random sessions.
module rewind_history_buffer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 128;

    // Op code 3 has no meaning; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One popped snapshot as the block should emit it.
    typedef struct packed {
        rhb_pkg::t_pose pose;
        logic [7:0]     left;
    } t_pop;

    logic i_clk;
    logic i_rst_n;

    rhb_in_if  in_ch ();
    rhb_out_if out_ch ();
    rhb_cfg_if cfg_ch ();

    rewind_history_buffer_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // Our own copy of the configuration, updated when a register write is accepted.
    logic [19:0] rec_interval;
    logic [7:0]  max_keep;
    logic [7:0]  pop_every;

    // Our own copy of the history: mode, timers and the ring of snapshots.
    logic           in_rewind;
    logic [20:0]    rec_timer;
    logic [7:0]     tick_count;
    int             oldest;
    int             kept;
    rhb_pkg::t_pose history [DEPTH];

    // Snapshots that the block owes us, oldest first.
    t_pop expected_pops [$];

    int fail_count;
    int items_sent;
    int hold_left;
    bit in_idle_on;
    bit out_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous bound on the whole run; a hang anywhere ends up here.
    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // Gap before the next item on either side; zero when that side runs flat out.
    function automatic int draw_gap(input bit idle_on);
        if (!idle_on) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Random words lean on the extremes now and then.
    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return 32'h8000_0000;
        end
        if (r == 1) begin
            return 32'h7fff_ffff;
        end
        return $urandom;
    endfunction

    function automatic logic [15:0] rand_half();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return 16'h8000;
        end
        if (r == 1) begin
            return 16'h7fff;
        end
        return 16'($urandom);
    endfunction

    function automatic rhb_pkg::t_pose rand_pose();
        rhb_pkg::t_pose p;
        p.x     = rand_word();
        p.y     = rand_word();
        p.z     = rand_word();
        p.pitch = rand_half();
        p.yaw   = rand_half();
        p.roll  = rand_half();
        return p;
    endfunction

    // A pose built from one word and one half, with the complements mixed in.
    function automatic rhb_pkg::t_pose flat_pose(input logic [31:0] w, input logic [15:0] h);
        rhb_pkg::t_pose p;
        p.x     = w;
        p.y     = ~w;
        p.z     = w;
        p.pitch = h;
        p.yaw   = ~h;
        p.roll  = h;
        return p;
    endfunction

    // Elapsed times mostly scaled to the current interval, so that snapshots are
    // taken every few ticks, with the edges of the range mixed in.
    function automatic logic [19:0] pick_delta();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 20'd0;
        end
        if (r == 1) begin
            return 20'd1000000;
        end
        if (r < 4) begin
            return 20'($urandom_range(0, 1000000));
        end
        return 20'($urandom_range(0, rec_interval));
    endfunction

    function automatic logic [19:0] pick_interval();
        int r;
        r = $urandom_range(0, 7);
        case (r)
            0: return 20'd0;
            1: return 20'd1;
            2: return 20'd1000000;
            3: return 20'($urandom_range(1, 1000));
            default: return 20'($urandom_range(1, 1000000));
        endcase
    endfunction

    // Small maximums make the oldest-entry drop happen often.
    function automatic logic [7:0] pick_max();
        int r;
        r = $urandom_range(0, 7);
        case (r)
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd128;
            3: return 8'($urandom_range(129, 255));
            4: return 8'($urandom_range(2, 128));
            default: return 8'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [7:0] pick_every();
        int r;
        r = $urandom_range(0, 5);
        case (r)
            0: return 8'd0;
            1: return 8'd2;
            2: return 8'($urandom_range(3, 6));
            default: return 8'd1;
        endcase
    endfunction

    function automatic void apply_register(input logic [rhb_pkg::CFG_IW-1:0] index,
                                           input logic [rhb_pkg::CFG_DW-1:0] value);
        case (index)
            rhb_pkg::CFG_RECORD_INTERVAL: rec_interval = value[19:0];
            rhb_pkg::CFG_MAX_SNAPSHOTS:   max_keep     = value[7:0];
            rhb_pkg::CFG_REWIND_TICK:     pop_every    = value[7:0];
            default: ;
        endcase
    endfunction

    // Moves our copy of the history by one accepted item. A popping tick queues
    // the snapshot that the block has to emit for it.
    function automatic void advance_history(input logic [1:0] op, input logic [19:0] delta,
                                            input rhb_pkg::t_pose p);
        int   limit;
        int   every;
        int   slot;
        t_pop res;
        case (op)
            rhb_pkg::OP_START_REWIND: in_rewind = 1'b1;
            rhb_pkg::OP_STOP_REWIND:  in_rewind = 1'b0;
            rhb_pkg::OP_TICK: begin
                if (!in_rewind) begin
                    // Recording: the timer runs, and a snapshot is taken when it
                    // reaches the interval.
                    rec_timer = rec_timer + delta;
                    if (rec_timer >= rec_interval) begin
                        rec_timer = '0;
                        limit = (int'(max_keep) < DEPTH) ? int'(max_keep) : DEPTH;
                        // A full ring loses its oldest entry before the write.
                        if (kept >= DEPTH) begin
                            oldest = (oldest + 1) % DEPTH;
                            kept   = DEPTH - 1;
                        end
                        slot = (oldest + kept) % DEPTH;
                        history[slot] = p;
                        kept++;
                        // Only one entry goes per push for the maximum, even if it
                        // was lowered well below the count.
                        if (kept > limit) begin
                            oldest = (oldest + 1) % DEPTH;
                            kept--;
                        end
                    end
                end else if (kept == 0) begin
                    // Nothing left to play back: rewinding ends quietly.
                    in_rewind = 1'b0;
                end else begin
                    every = (pop_every == 8'd0) ? 1 : int'(pop_every);
                    tick_count = tick_count + 8'd1;
                    if (int'(tick_count) >= every) begin
                        tick_count = '0;
                        slot = (oldest + kept - 1) % DEPTH;
                        kept--;
                        res.pose = history[slot];
                        res.left = 8'(kept);
                        expected_pops.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_pop();
        t_pop want;
        if (expected_pops.size() == 0) begin
            $error("result with nothing expected: out_x %h, entries_left %0d",
                   out_ch.out_x, out_ch.entries_left);
            fail_count++;
        end else begin
            want = expected_pops.pop_front();
            check_field("out_x", want.pose.x, out_ch.out_x);
            check_field("out_y", want.pose.y, out_ch.out_y);
            check_field("out_z", want.pose.z, out_ch.out_z);
            check_field("out_pitch", 32'(want.pose.pitch), 32'(out_ch.out_pitch));
            check_field("out_yaw", 32'(want.pose.yaw), 32'(out_ch.out_yaw));
            check_field("out_roll", 32'(want.pose.roll), 32'(out_ch.out_roll));
            check_field("entries_left", 32'(want.left), 32'(out_ch.entries_left));
        end
    endfunction

    // All three channels are watched at the rising edge, where the values driven
    // at the falling edge are stable and the block has not yet updated.
    always @(posedge i_clk) begin : watch_channels
        rhb_pkg::t_pose seen;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                check_pop();
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_register(cfg_ch.index, cfg_ch.data);
            end
            if (in_ch.valid && in_ch.ready) begin
                seen.x     = in_ch.pos_x;
                seen.y     = in_ch.pos_y;
                seen.z     = in_ch.pos_z;
                seen.pitch = in_ch.ang_pitch;
                seen.yaw   = in_ch.ang_yaw;
                seen.roll  = in_ch.ang_roll;
                advance_history(in_ch.op, in_ch.delta_us, seen);
            end
        end
    end

    // Result receiver: after each accepted result it waits a drawn number of
    // cycles, and a requested hold keeps ready low for a long stretch.
    initial begin : drive_result_ready
        int gap;
        out_ch.ready = 1'b0;
        gap = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (gap > 0) begin
                out_ch.ready <= 1'b0;
                gap--;
            end else begin
                out_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                gap = draw_gap(out_idle_on);
            end
        end
    end

    // Offers one item and returns at the falling edge after it was taken. Valid
    // stays high when the next item follows without a gap.
    task automatic send_item(input logic [1:0] op, input logic [19:0] delta,
                             input rhb_pkg::t_pose p);
        int gap;
        gap = draw_gap(in_idle_on);
        repeat (gap) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.delta_us  <= delta;
        in_ch.pos_x     <= p.x;
        in_ch.pos_y     <= p.y;
        in_ch.pos_z     <= p.z;
        in_ch.ang_pitch <= p.pitch;
        in_ch.ang_yaw   <= p.yaw;
        in_ch.ang_roll  <= p.roll;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (op != OP_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic send_ticks(input int count, input bit scaled);
        repeat (count) begin
            send_item(rhb_pkg::OP_TICK, scaled ? pick_delta() : 20'd0, rand_pose());
        end
    endtask

    // Stops offering items and waits until every owed snapshot has come out,
    // and then for a tick that is still in flight.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_pops.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rhb_pkg::CFG_IW-1:0] index,
                             input logic [rhb_pkg::CFG_DW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [19:0] interval, input logic [7:0] keep,
                             input logic [7:0] every);
        settle();
        write_reg(rhb_pkg::CFG_RECORD_INTERVAL, rhb_pkg::CFG_DW'(interval));
        write_reg(rhb_pkg::CFG_MAX_SNAPSHOTS, rhb_pkg::CFG_DW'(keep));
        write_reg(rhb_pkg::CFG_REWIND_TICK, rhb_pkg::CFG_DW'(every));
    endtask

    // Default settings: the timer edges, extreme poses, a pop, start and stop
    // repeated, rewinding run dry and recording picked up again afterwards.
    task automatic test_directed();
        send_item(OP_UNUSED, 20'd1000000, flat_pose(32'h7fff_ffff, 16'h7fff));
        send_item(rhb_pkg::OP_TICK, 20'd0, flat_pose(32'h0000_0001, 16'h0001));
        send_item(rhb_pkg::OP_TICK, 20'd49999, flat_pose(32'h1234_5678, 16'h1234));
        send_item(rhb_pkg::OP_TICK, 20'd1, flat_pose(32'h7fff_ffff, 16'h7fff));
        send_item(rhb_pkg::OP_TICK, 20'd1000000, flat_pose(32'h8000_0000, 16'h8000));
        send_item(rhb_pkg::OP_TICK, 20'd1000000, flat_pose(32'hffff_ffff, 16'hffff));
        send_item(rhb_pkg::OP_TICK, 20'd50000, flat_pose(32'h5555_aaaa, 16'h55aa));
        send_item(rhb_pkg::OP_STOP_REWIND, 20'd0, flat_pose(32'h0, 16'h0));
        send_item(rhb_pkg::OP_START_REWIND, 20'd0, flat_pose(32'h0, 16'h0));
        send_item(rhb_pkg::OP_TICK, 20'd0, flat_pose(32'h0, 16'h0));
        send_item(rhb_pkg::OP_START_REWIND, 20'd1000000, flat_pose(32'h0f0f_0f0f, 16'h0f0f));
        send_item(rhb_pkg::OP_STOP_REWIND, 20'd1000000, flat_pose(32'hf0f0_f0f0, 16'hf0f0));
        send_item(rhb_pkg::OP_TICK, 20'd0, flat_pose(32'h0, 16'h0));
        send_item(rhb_pkg::OP_START_REWIND, 20'd0, flat_pose(32'h0, 16'h0));
        // Three pops, then a tick on the empty store ends rewinding.
        send_ticks(4, 1'b0);
        send_item(rhb_pkg::OP_TICK, 20'd1000000, flat_pose(32'h0000_0000, 16'h0000));
        send_item(rhb_pkg::OP_START_REWIND, 20'd0, flat_pose(32'h0, 16'h0));
        send_ticks(2, 1'b0);
        send_item(OP_UNUSED, 20'd0, flat_pose(32'h8000_0000, 16'h8000));
    endtask

    // Register extremes: zero interval, a maximum above the ring size with the
    // ring overflowing, a lowered maximum, a zero maximum, zero and largest
    // rewind tick intervals, and a record interval of one million.
    task automatic test_config_extremes();
        configure(20'd0, 8'd255, 8'd0);
        send_ticks(140, 1'b1);
        send_item(rhb_pkg::OP_START_REWIND, pick_delta(), rand_pose());
        send_ticks(132, 1'b0);
        send_item(rhb_pkg::OP_STOP_REWIND, pick_delta(), rand_pose());

        configure(20'd1, 8'd100, 8'd2);
        repeat (40) send_item(rhb_pkg::OP_TICK, 20'd1, rand_pose());
        configure(20'd1, 8'd5, 8'd2);
        repeat (3) send_item(rhb_pkg::OP_TICK, 20'd1, rand_pose());
        send_item(rhb_pkg::OP_START_REWIND, pick_delta(), rand_pose());
        send_ticks(20, 1'b0);
        send_item(rhb_pkg::OP_STOP_REWIND, pick_delta(), rand_pose());

        // Empty the store, then push with nothing allowed to stay.
        configure(20'd1, 8'd5, 8'd1);
        send_item(rhb_pkg::OP_START_REWIND, pick_delta(), rand_pose());
        send_ticks(60, 1'b0);
        configure(20'd1, 8'd0, 8'd1);
        repeat (5) send_item(rhb_pkg::OP_TICK, 20'd1, rand_pose());
        send_item(rhb_pkg::OP_START_REWIND, pick_delta(), rand_pose());
        send_ticks(2, 1'b0);
        send_item(rhb_pkg::OP_STOP_REWIND, pick_delta(), rand_pose());

        configure(20'd1000000, 8'd128, 8'd255);
        repeat (10) send_item(rhb_pkg::OP_TICK, 20'd1000000, rand_pose());
        send_item(rhb_pkg::OP_START_REWIND, pick_delta(), rand_pose());
        in_idle_on = 1'b0;
        send_ticks(300, 1'b1);
        in_idle_on = 1'b1;
        send_item(rhb_pkg::OP_STOP_REWIND, pick_delta(), rand_pose());
    endtask

    // The receiver holds off for a long stretch while popping ticks keep coming,
    // so the result path fills and the input side has to stall.
    task automatic test_backpressure();
        configure(20'd0, 8'd128, 8'd1);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        send_ticks(60, 1'b1);
        send_item(rhb_pkg::OP_START_REWIND, pick_delta(), rand_pose());
        in_ch.valid <= 1'b0;
        hold_left = 200;
        @(negedge i_clk);
        send_ticks(50, 1'b1);
        send_item(rhb_pkg::OP_STOP_REWIND, pick_delta(), rand_pose());
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // A session item is usually what the session calls for, sometimes a stray
    // start, stop or unused op.
    task automatic send_session_item(input logic [1:0] op);
        logic [1:0] kind;
        int         r;
        kind = op;
        if ($urandom_range(0, 15) == 0) begin
            r = $urandom_range(0, 2);
            case (r)
                0: kind = rhb_pkg::OP_START_REWIND;
                1: kind = rhb_pkg::OP_STOP_REWIND;
                default: kind = OP_UNUSED;
            endcase
        end
        send_item(kind, pick_delta(), rand_pose());
    endtask

    // Random record-then-rewind sessions under a fresh random configuration per
    // phase; some rewinds are stopped early, others run the store dry.
    task automatic test_random_sessions();
        int goal;
        int n;
        for (int phase = 0; phase < 8; phase++) begin
            configure(pick_interval(), pick_max(), pick_every());
            in_idle_on  = (phase % 4) != 3;
            out_idle_on = (phase % 4) != 2;
            goal = items_sent + 75;
            while (items_sent < goal) begin
                n = $urandom_range(1, 40);
                repeat (n) send_session_item(rhb_pkg::OP_TICK);
                send_session_item(rhb_pkg::OP_START_REWIND);
                n = $urandom_range(1, 60);
                repeat (n) send_session_item(rhb_pkg::OP_TICK);
                if ($urandom_range(0, 1) == 1) begin
                    send_session_item(rhb_pkg::OP_STOP_REWIND);
                end
            end
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    initial begin : run_tests
        // Known values on every input from the first moment.
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = rhb_pkg::OP_TICK;
        in_ch.delta_us     = '0;
        in_ch.pos_x        = '0;
        in_ch.pos_y        = '0;
        in_ch.pos_z        = '0;
        in_ch.ang_pitch    = '0;
        in_ch.ang_yaw      = '0;
        in_ch.ang_roll     = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = rhb_pkg::CFG_RECORD_INTERVAL;
        cfg_ch.data        = '0;
        fail_count         = 0;
        items_sent         = 0;
        hold_left          = 0;
        in_idle_on         = 1'b1;
        out_idle_on        = 1'b1;

        // Our copy starts from the reset state of the block.
        rec_interval = rhb_pkg::RECORD_INTERVAL_RST;
        max_keep     = rhb_pkg::MAX_SNAPSHOTS_RST;
        pop_every    = rhb_pkg::REWIND_TICK_RST;
        in_rewind    = 1'b0;
        rec_timer    = '0;
        tick_count   = '0;
        oldest       = 0;
        kept         = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_sessions();

        settle();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
